FILE: rtl/lod_pkg.sv
// Shared types, widths and constants of the link outage detector.
// Holds the divide-by-1000 digit helpers used by the duration pipeline.
// No dependencies.
package lod_pkg;

    localparam int TS_W              = 48;
    localparam int DUR_W             = 40;
    localparam int THR_W             = 4;
    localparam int MAX_THRESHOLD_DEF = 8;
    localparam logic [THR_W-1:0] THRESH_RESET = THR_W'(3);

    localparam int MS_PER_S = 1000;

    // Magnitude plus rounding offset, split into 16-bit chunks for long division.
    localparam int X_W     = TS_W + 1;
    localparam int CHUNK_W = 16;
    localparam int TOP_W   = X_W - 2 * CHUNK_W;
    localparam int Q1_W    = 8;
    localparam int DIG_W   = 16;
    localparam int REM_W   = 10;
    localparam int V_W     = REM_W + CHUNK_W;
    localparam int DIGQ_W  = 17;

    // ceil(2^36 / 1000): exact quotient for every dividend below 2^26
    localparam int MAGIC_SH = 36;
    localparam int MAGIC_W  = 27;
    localparam logic [MAGIC_W-1:0] DIV_MAGIC = MAGIC_W'(68719477);

    typedef struct packed {
        logic [TS_W-1:0] start_ms;
        logic [TS_W-1:0] end_ms;
        logic            ongoing;
    } lod_event_t;

    function automatic logic [DIGQ_W-1:0] div_digit(input logic [V_W-1:0] v);
        logic [V_W+MAGIC_W-1:0] prod;
        prod = (V_W + MAGIC_W)'(v) * (V_W + MAGIC_W)'(DIV_MAGIC);
        return prod[MAGIC_SH +: DIGQ_W];
    endfunction

    // v - q * 1000, done with shifts
    function automatic logic [REM_W-1:0] rem_digit(input logic [V_W-1:0] v,
                                                   input logic [DIG_W-1:0] q);
        logic [V_W-1:0] qw;
        logic [V_W-1:0] diff;
        qw   = V_W'(q);
        diff = v - ((qw << 10) - (qw << 4) - (qw << 3));
        return diff[REM_W-1:0];
    endfunction

endpackage

FILE: rtl/link_outage_detector.sv
// Link outage detector: one transaction per cycle while m_ready does not hold the pipeline;
// a result passes from the input register through the tracker's event register and the
// four-step divide-by-1000 pipeline into the output register.
// Reset (aresetn low at a clock edge) empties the pipeline, clears the window,
// miss run and open outage, and sets miss_threshold to 3.
module link_outage_detector
    import lod_pkg::*;
#(
    parameter int MAX_THRESHOLD = MAX_THRESHOLD_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [THR_W-1:0]        cfg_wr_data,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_action,
    input  logic [TS_W-1:0]         s_timestamp_ms,
    input  logic                    s_record_complete,
    input  logic                    s_missed,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [TS_W-1:0]         m_outage_start_ms,
    output logic [TS_W-1:0]         m_outage_end_ms,
    output logic signed [DUR_W-1:0] m_duration_s,
    output logic                    m_ongoing
);

    logic [THR_W-1:0] thr_reg;
    logic             ev_valid;
    logic             ev_ready;
    lod_event_t       ev;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THRESH_RESET;
        end else if (cfg_wr_en) begin
            thr_reg <= cfg_wr_data;
        end
    end

    lod_tracker #(
        .MAX_THRESHOLD(MAX_THRESHOLD)
    ) u_tracker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .miss_threshold   (thr_reg),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_action         (s_action),
        .s_timestamp_ms   (s_timestamp_ms),
        .s_record_complete(s_record_complete),
        .s_missed         (s_missed),
        .ev_valid         (ev_valid),
        .ev_ready         (ev_ready),
        .ev               (ev)
    );

    lod_duration u_duration (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .in_valid         (ev_valid),
        .in_ready         (ev_ready),
        .ev               (ev),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_outage_start_ms(m_outage_start_ms),
        .m_outage_end_ms  (m_outage_end_ms),
        .m_duration_s     (m_duration_s),
        .m_ongoing        (m_ongoing)
    );

    // An outage event only exists for an open outage
    a_event_has_start: assert property (@(posedge aclk) disable iff (!aresetn)
        ev_valid |-> ev.start_ms != '0)
        else $error("outage event without a start time");

    // Forward outages never report a negative duration
    a_sign_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_outage_end_ms >= m_outage_start_ms) |-> !m_duration_s[DUR_W-1])
        else $error("negative duration for end at or after start");

    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !ev_valid)
        else $error("result pending right after reset");

endmodule

FILE: rtl/lod_tracker.sv
// Input register, miss window, miss run and open-outage tracking.
// Emits one outage event per outage, when it closes or the stream ends. Depends on lod_pkg.
module lod_tracker
    import lod_pkg::*;
#(
    parameter int MAX_THRESHOLD = MAX_THRESHOLD_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [THR_W-1:0] miss_threshold,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic             s_action,
    input  logic [TS_W-1:0]  s_timestamp_ms,
    input  logic             s_record_complete,
    input  logic             s_missed,
    output logic             ev_valid,
    input  logic             ev_ready,
    output lod_event_t       ev
);

    localparam int CNT_W = $clog2(MAX_THRESHOLD + 1);
    localparam int IDX_W = (MAX_THRESHOLD > 1) ? $clog2(MAX_THRESHOLD) : 1;
    localparam int CMP_W = (CNT_W > THR_W) ? CNT_W : THR_W;
    localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_THRESHOLD);

    logic             in_valid_reg;
    logic             act_reg;
    logic [TS_W-1:0]  ts_reg;
    logic             cmpl_reg;
    logic             miss_reg;

    logic [TS_W-1:0]  win_reg [MAX_THRESHOLD];
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [CNT_W-1:0] run_reg, run_next;
    logic [TS_W-1:0]  open_reg, open_next;

    logic             ev_valid_reg;
    lod_event_t       ev_reg;

    logic             ev_load;
    logic             proc;
    logic             push;
    logic             emit;
    logic             ongoing;
    logic [CMP_W-1:0] thr_cmp;
    logic [CNT_W-1:0] thr;
    logic [CNT_W:0]   fill_inc;
    logic [CNT_W-1:0] new_fill;
    logic [CNT_W-1:0] fill_m2;
    logic [IDX_W-1:0] old_idx;
    logic [TS_W-1:0]  oldest;
    logic [CNT_W-1:0] run_inc;

    assign ev_load = !ev_valid_reg || ev_ready;
    assign proc    = in_valid_reg && ev_load;
    assign s_ready = !in_valid_reg || ev_load;

    // Clamp the threshold into 1..MAX_THRESHOLD
    always_comb begin
        thr_cmp = CMP_W'(miss_threshold);
        priority if (thr_cmp == '0) begin
            thr_cmp = CMP_W'(1);
        end else if (thr_cmp > MAX_CMP) begin
            thr_cmp = MAX_CMP;
        end
        thr = thr_cmp[CNT_W-1:0];
    end

    // Window keeps the newest entries first; the oldest valid one sits at fill - 1.
    assign fill_inc = {1'b0, fill_reg} + (CNT_W + 1)'(1);
    assign new_fill = (fill_inc > {1'b0, thr}) ? thr : fill_inc[CNT_W-1:0];
    assign fill_m2  = new_fill - CNT_W'(2);
    assign old_idx  = fill_m2[IDX_W-1:0];
    assign oldest   = (new_fill == CNT_W'(1)) ? ts_reg : win_reg[old_idx];
    assign run_inc  = (run_reg < thr) ? run_reg + CNT_W'(1) : run_reg;

    always_comb begin
        fill_next = fill_reg;
        run_next  = run_reg;
        open_next = open_reg;
        push      = 1'b0;
        emit      = 1'b0;
        ongoing   = 1'b0;
        if (proc) begin
            if (act_reg) begin
                emit      = (open_reg != '0);
                ongoing   = 1'b1;
                fill_next = '0;
                run_next  = '0;
                open_next = '0;
            end else begin
                push      = 1'b1;
                fill_next = new_fill;
                if (cmpl_reg) begin
                    if (miss_reg) begin
                        run_next = run_inc;
                        if (run_inc >= thr && open_reg == '0) begin
                            open_next = oldest;
                        end
                    end else begin
                        emit      = (open_reg != '0);
                        open_next = '0;
                        run_next  = '0;
                        fill_next = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            fill_reg     <= '0;
            run_reg      <= '0;
            open_reg     <= '0;
            ev_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            fill_reg <= fill_next;
            run_reg  <= run_next;
            open_reg <= open_next;
            if (proc) begin
                ev_valid_reg <= emit;
            end else if (ev_ready) begin
                ev_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            act_reg  <= s_action;
            ts_reg   <= s_timestamp_ms;
            cmpl_reg <= s_record_complete;
            miss_reg <= s_missed;
        end
        if (push) begin
            win_reg[0] <= ts_reg;
            for (int i = 1; i < MAX_THRESHOLD; i++) begin
                win_reg[i] <= win_reg[i-1];
            end
        end
        if (proc) begin
            ev_reg.start_ms <= open_reg;
            ev_reg.end_ms   <= ts_reg;
            ev_reg.ongoing  <= ongoing;
        end
    end

    assign ev_valid = ev_valid_reg;
    assign ev       = ev_reg;

endmodule

FILE: rtl/lod_duration.sv
// Duration pipeline: |end - start| + 500, long division by 1000 in 16-bit
// chunks, sign restore, and the result register. Depends on lod_pkg.
module lod_duration
    import lod_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  lod_event_t              ev,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [TS_W-1:0]         m_outage_start_ms,
    output logic [TS_W-1:0]         m_outage_end_ms,
    output logic signed [DUR_W-1:0] m_duration_s,
    output logic                    m_ongoing
);

    typedef struct packed {
        lod_event_t evt;
        logic       neg;
    } carry_t;

    localparam logic [X_W-1:0] HALF = X_W'(MS_PER_S / 2);

    logic a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg, m_valid_reg;
    logic load_a, load_b, load_c, load_d, load_out;

    carry_t a_car_reg, b_car_reg, c_car_reg, d_car_reg;
    logic [X_W-1:0] a_x_reg;

    logic [Q1_W-1:0]      b_q1_reg;
    logic [TOP_W-1:0]     b_v1_reg;
    logic [2*CHUNK_W-1:0] b_lo_reg;

    logic [Q1_W-1:0]    c_q1_reg;
    logic [DIG_W-1:0]   c_q2_reg;
    logic [V_W-1:0]     c_v2_reg;
    logic [CHUNK_W-1:0] c_lo_reg;

    logic [DUR_W-1:0] d_quot_reg;

    logic [TS_W-1:0]         m_start_reg, m_end_reg;
    logic                    m_ongoing_reg;
    logic signed [DUR_W-1:0] m_dur_reg;

    logic             ge;
    logic [X_W-1:0]   x_next;
    logic [DIGQ_W-1:0] q1_full, q2_full, q3_full;
    logic [REM_W-1:0] r1, r2;
    logic [V_W-1:0]   v2, v3;
    logic [DUR_W-1:0] dur_next;

    assign load_out = !m_valid_reg || m_ready;
    assign load_d   = !d_valid_reg || load_out;
    assign load_c   = !c_valid_reg || load_d;
    assign load_b   = !b_valid_reg || load_c;
    assign load_a   = !a_valid_reg || load_b;
    assign in_ready = load_a;

    assign ge     = ev.end_ms >= ev.start_ms;
    assign x_next = ge ? (X_W'(ev.end_ms) - X_W'(ev.start_ms) + HALF)
                       : (X_W'(ev.start_ms) - X_W'(ev.end_ms) + HALF);

    assign q1_full = div_digit(V_W'(a_x_reg[X_W-1:2*CHUNK_W]));

    assign r1      = rem_digit(V_W'(b_v1_reg), DIG_W'(b_q1_reg));
    assign v2      = {r1, b_lo_reg[2*CHUNK_W-1:CHUNK_W]};
    assign q2_full = div_digit(v2);

    assign r2      = rem_digit(c_v2_reg, c_q2_reg);
    assign v3      = {r2, c_lo_reg};
    assign q3_full = div_digit(v3);

    assign dur_next = d_car_reg.neg ? (DUR_W'(0) - d_quot_reg) : d_quot_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (load_a) a_valid_reg <= in_valid;
            if (load_b) b_valid_reg <= a_valid_reg;
            if (load_c) c_valid_reg <= b_valid_reg;
            if (load_d) d_valid_reg <= c_valid_reg;
            if (load_out) m_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_a && in_valid) begin
            a_car_reg.evt <= ev;
            a_car_reg.neg <= !ge;
            a_x_reg       <= x_next;
        end
        if (load_b && a_valid_reg) begin
            b_car_reg <= a_car_reg;
            b_q1_reg  <= q1_full[Q1_W-1:0];
            b_v1_reg  <= a_x_reg[X_W-1:2*CHUNK_W];
            b_lo_reg  <= a_x_reg[2*CHUNK_W-1:0];
        end
        if (load_c && b_valid_reg) begin
            c_car_reg <= b_car_reg;
            c_q1_reg  <= b_q1_reg;
            c_q2_reg  <= q2_full[DIG_W-1:0];
            c_v2_reg  <= v2;
            c_lo_reg  <= b_lo_reg[CHUNK_W-1:0];
        end
        if (load_d && c_valid_reg) begin
            d_car_reg  <= c_car_reg;
            d_quot_reg <= {c_q1_reg, c_q2_reg, q3_full[DIG_W-1:0]};
        end
        if (load_out && d_valid_reg) begin
            m_start_reg   <= d_car_reg.evt.start_ms;
            m_end_reg     <= d_car_reg.evt.end_ms;
            m_ongoing_reg <= d_car_reg.evt.ongoing;
            m_dur_reg     <= dur_next;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_outage_start_ms = m_start_reg;
    assign m_outage_end_ms   = m_end_reg;
    assign m_duration_s      = m_dur_reg;
    assign m_ongoing         = m_ongoing_reg;

endmodule

FILE: bench/tb.sv
// Self-checking testbench for link_outage_detector: directed and random ping streams.
// Holds its own outage tracker that predicts every result and checks it field by field.
// Depends on lod_pkg and the link_outage_detector RTL.
module tb
    import lod_pkg::*;
();

    localparam logic ACT_RECORD = 1'b0;
    localparam logic ACT_END    = 1'b1;

    localparam int WIN_DEPTH    = MAX_THRESHOLD_DEF;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES  = 150;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 500;

    localparam logic [TS_W-1:0] TS_MAX = '1;

    typedef struct {
        logic [TS_W-1:0]         start_ms;
        logic [TS_W-1:0]         end_ms;
        logic signed [DUR_W-1:0] dur_s;
        logic                    ongoing;
    } outage_t;

    logic                    aclk              = 1'b0;
    logic                    aresetn           = 1'b0;
    logic                    cfg_wr_en         = 1'b0;
    logic [THR_W-1:0]        cfg_wr_data       = '0;
    logic                    s_valid           = 1'b0;
    logic                    s_ready;
    logic                    s_action          = 1'b0;
    logic [TS_W-1:0]         s_timestamp_ms    = '0;
    logic                    s_record_complete = 1'b0;
    logic                    s_missed          = 1'b0;
    logic                    m_valid;
    logic                    m_ready           = 1'b0;
    logic [TS_W-1:0]         m_outage_start_ms;
    logic [TS_W-1:0]         m_outage_end_ms;
    logic signed [DUR_W-1:0] m_duration_s;
    logic                    m_ongoing;

    // tracker state, mirrors the block
    logic [TS_W-1:0]  win_ts [WIN_DEPTH];
    int               win_fill;
    int               miss_run;
    logic [TS_W-1:0]  open_start;
    logic [THR_W-1:0] thr_reg = THRESH_RESET;

    outage_t pending_outages[$];

    bit tx_idle_en = 1'b1;
    bit rx_idle_en = 1'b1;
    bit hold_go    = 1'b0;
    int hold_left  = 0;
    int errors     = 0;
    int cycle_count = 0;

    link_outage_detector dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_action          (s_action),
        .s_timestamp_ms    (s_timestamp_ms),
        .s_record_complete (s_record_complete),
        .s_missed          (s_missed),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_outage_start_ms (m_outage_start_ms),
        .m_outage_end_ms   (m_outage_end_ms),
        .m_duration_s      (m_duration_s),
        .m_ongoing         (m_ongoing)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ---------------- outage tracker ----------------

    function automatic int active_threshold();
        int t;
        t = thr_reg;
        if (t < 1) t = 1;
        if (t > WIN_DEPTH) t = WIN_DEPTH;
        return t;
    endfunction

    function automatic void shift_out_oldest(input int n);
        int i;
        if (n == 0 || n > win_fill) return;
        for (i = 0; i + n < win_fill; i++) win_ts[i] = win_ts[i + n];
        for (i = win_fill - n; i < win_fill; i++) win_ts[i] = '0;
        win_fill -= n;
    endfunction

    function automatic void clear_tracker();
        foreach (win_ts[i]) win_ts[i] = '0;
        win_fill   = 0;
        miss_run   = 0;
        open_start = '0;
    endfunction

    // (to - from) / 1000, rounded half away from zero
    function automatic logic signed [DUR_W-1:0] rounded_seconds(input logic [TS_W-1:0] from_ms,
                                                                input logic [TS_W-1:0] to_ms);
        logic [63:0] mag;
        if (to_ms >= from_ms) begin
            mag = (64'(to_ms) - 64'(from_ms) + 64'(MS_PER_S / 2)) / 64'(MS_PER_S);
            return mag[DUR_W-1:0];
        end
        mag = (64'(from_ms) - 64'(to_ms) + 64'(MS_PER_S / 2)) / 64'(MS_PER_S);
        return -mag[DUR_W-1:0];
    endfunction

    function automatic void queue_outage(input logic [TS_W-1:0] stop_ms, input logic still_open);
        outage_t o;
        o.start_ms = open_start;
        o.end_ms   = stop_ms;
        o.dur_s    = rounded_seconds(open_start, stop_ms);
        o.ongoing  = still_open;
        pending_outages = {pending_outages, o};
    endfunction

    function automatic void predict_outage(input logic act, input logic [TS_W-1:0] ts,
                                           input logic done, input logic lost);
        int thr;
        thr = active_threshold();
        if (act == ACT_END) begin
            if (open_start != '0) queue_outage(ts, 1'b1);
            clear_tracker();
            return;
        end
        if (win_fill >= WIN_DEPTH) shift_out_oldest(1);
        win_ts[win_fill] = ts;
        win_fill++;
        if (win_fill > thr) shift_out_oldest(win_fill - thr);
        if (!done) return;
        if (lost) begin
            if (miss_run < thr) miss_run++;
            // a start of zero means no outage, so it cannot open one
            if (miss_run >= thr && open_start == '0 && win_fill > 0) open_start = win_ts[0];
            return;
        end
        if (open_start != '0) queue_outage(ts, 1'b0);
        clear_tracker();
    endfunction

    // ---------------- result checker ----------------

    always @(posedge aclk) begin : check_results
        outage_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_outages.size() == 0) begin
                $error("result with no outage pending: start %0d end %0d",
                       m_outage_start_ms, m_outage_end_ms);
                errors++;
            end else begin
                want = pending_outages.pop_front();
                if (m_outage_start_ms !== want.start_ms) begin
                    $error("outage_start_ms: expected %0d, got %0d",
                           want.start_ms, m_outage_start_ms);
                    errors++;
                end
                if (m_outage_end_ms !== want.end_ms) begin
                    $error("outage_end_ms: expected %0d, got %0d", want.end_ms, m_outage_end_ms);
                    errors++;
                end
                if (m_duration_s !== want.dur_s) begin
                    $error("duration_s: expected %0d, got %0d", want.dur_s, m_duration_s);
                    errors++;
                end
                if (m_ongoing !== want.ongoing) begin
                    $error("ongoing: expected %0d, got %0d", want.ongoing, m_ongoing);
                    errors++;
                end
            end
        end
    end

    // ---------------- result receiver ----------------

    always @(posedge aclk) begin
        if (hold_go) begin
            hold_go   = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= !rx_idle_en || ($urandom_range(99) >= 20);
        end
    end

    // ---------------- stimulus helpers ----------------

    function automatic logic [TS_W-1:0] rand_ts();
        return {16'($urandom), $urandom};
    endfunction

    // mostly forward in time, now and then a step back
    function automatic logic [TS_W-1:0] next_time(input logic [TS_W-1:0] now);
        if ($urandom_range(99) < 5) return now - TS_W'($urandom_range(3000));
        return now + TS_W'($urandom_range(1, 4000));
    endfunction

    task automatic send_item(input logic act, input logic [TS_W-1:0] ts,
                             input logic done, input logic lost);
        int gap;
        if (tx_idle_en && $urandom_range(99) < 10) begin
            gap = $urandom_range(1, 4);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_action          <= act;
        s_timestamp_ms    <= ts;
        s_record_complete <= done;
        s_missed          <= lost;
        do @(posedge aclk); while (!s_ready);
        predict_outage(act, ts, done, lost);
    endtask

    task automatic ping_lost(input logic [TS_W-1:0] ts);
        send_item(ACT_RECORD, ts, 1'b1, 1'b1);
    endtask

    task automatic ping_ok(input logic [TS_W-1:0] ts);
        send_item(ACT_RECORD, ts, 1'b1, 1'b0);
    endtask

    // hold the sender until every outage is reported and the pipeline is empty
    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_outages.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_threshold(input logic [THR_W-1:0] value);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        thr_reg = value;
    endtask

    // ---------------- tests ----------------

    // threshold 3 from reset; incomplete record joins the window, rounding of a half second
    task automatic test_outage_basic();
        ping_lost(48'd1000);
        send_item(ACT_RECORD, 48'd1500, 1'b0, 1'b1);
        ping_lost(48'd2000);
        ping_lost(48'd3000);
        ping_ok(48'd4000);
        // miss run saturates; start stays at the oldest window entry
        repeat (5) ping_lost(48'd5000);
        ping_ok(48'd9999);
    endtask

    task automatic test_zero_start();
        repeat (3) ping_lost('0);
        ping_ok(48'd10);
    endtask

    task automatic test_end_of_stream();
        ping_lost(TS_MAX - 48'd2000);
        ping_lost(TS_MAX - 48'd1000);
        ping_lost(TS_MAX);
        send_item(ACT_END, '0, 1'b1, 1'b1);
        send_item(ACT_END, TS_MAX, 1'b0, 1'b0);
        // recovery stamped before the outage start
        ping_lost(48'd60000);
        ping_lost(48'd70000);
        ping_lost(48'd80000);
        ping_ok(48'd58500);
    endtask

    task automatic test_threshold_limits();
        int k;
        set_threshold(4'd15);
        for (k = 0; k < 5; k++) ping_lost(TS_W'(10000 + 1000 * k));
        // lowered mid-stream: next record trims the window to the newest entries
        set_threshold(4'd2);
        ping_lost(48'd15000);
        ping_ok(48'd16499);
        set_threshold(4'd0);
        ping_lost(48'd7);
        ping_ok(48'd7);
    endtask

    task automatic test_backpressure();
        logic [TS_W-1:0] now;
        set_threshold(4'd1);
        tx_idle_en = 1'b0;
        now = 48'd5000;
        hold_go = 1'b1;
        repeat (20) begin
            ping_lost(now);
            now += 48'd1700;
            ping_ok(now);
            now += 48'd900;
        end
        drain_results();
        tx_idle_en = 1'b1;
    endtask

    task automatic test_random_traffic();
        logic [TS_W-1:0] now;
        int sent;
        int phase;
        int k;
        int kind;
        now  = rand_ts();
        sent = 0;
        for (phase = 0; phase < 5; phase++) begin
            case (phase)
                0: set_threshold(4'd1);
                1: set_threshold(4'd8);
                2: set_threshold(4'd15);
                3: set_threshold(4'd0);
                default: set_threshold(THR_W'($urandom_range(15)));
            endcase
            // one phase runs with no idling on either side
            tx_idle_en = (phase != 2);
            rx_idle_en = (phase != 2);
            while (sent < (phase + 1) * RANDOM_ITEMS / 5) begin
                kind = $urandom_range(99);
                if (kind < 8) begin
                    send_item(1'($urandom_range(1)), rand_ts(), 1'($urandom_range(1)),
                              1'($urandom_range(1)));
                    sent++;
                end else if (kind < 13) begin
                    send_item(ACT_END, now, 1'($urandom_range(1)), 1'($urandom_range(1)));
                    sent++;
                end else begin
                    k = $urandom_range(active_threshold() + 2);
                    repeat (k) begin
                        if ($urandom_range(9) == 0) begin
                            send_item(ACT_RECORD, now, 1'b0, 1'($urandom_range(1)));
                            sent++;
                        end
                        ping_lost(now);
                        sent++;
                        now = next_time(now);
                    end
                    // leave some runs open so they carry into the next sequence
                    if ($urandom_range(99) < 85) begin
                        ping_ok(now);
                        sent++;
                        now = next_time(now);
                    end
                end
            end
        end
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    initial begin
        clear_tracker();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_outage_basic();
        test_zero_start();
        test_end_of_stream();
        test_threshold_limits();
        test_backpressure();
        test_random_traffic();
        drain_results();
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
